// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCAK_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("scak assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SCAK_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("scak assertion failed");

`endif

// ===== rtl/core/scak_pkg.sv =====
package scak_pkg;

	localparam logic CMD_KEY  = 1'b0;
	localparam logic CMD_READ = 1'b1;

	localparam logic [7:0] SC_LSHIFT = 8'd42;
	localparam logic [7:0] SC_RSHIFT = 8'd54;
	localparam logic [7:0] SC_CAPS   = 8'd58;
	localparam logic [7:0] NO_KEY    = 8'hFF;
	localparam logic [6:0] ROM_LAST  = 7'd89;

	typedef struct packed {
		logic       command;
		logic [7:0] key_code;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       was_empty;
	} rsp_t;

	typedef struct packed {
		logic       push;
		logic [7:0] ch;
	} push_t;

	// Two-plane key ROM; plane 1 is the shifted plane.
	function automatic logic [7:0] rom_char(input logic plane, input logic [6:0] idx);
		logic [7:0] ch;
		case (idx)
			7'd2:  ch = plane ? 8'h21 : 8'h31;
			7'd3:  ch = plane ? 8'h40 : 8'h32;
			7'd4:  ch = plane ? 8'h23 : 8'h33;
			7'd5:  ch = plane ? 8'h24 : 8'h34;
			7'd6:  ch = plane ? 8'h25 : 8'h35;
			7'd7:  ch = plane ? 8'h3F : 8'h36;
			7'd8:  ch = plane ? 8'h26 : 8'h37;
			7'd9:  ch = plane ? 8'h2A : 8'h38;
			7'd10: ch = plane ? 8'h28 : 8'h39;
			7'd11: ch = plane ? 8'h29 : 8'h30;
			7'd12: ch = plane ? 8'h5F : 8'h2D;
			7'd13: ch = plane ? 8'h2B : 8'h3D;
			7'd16: ch = plane ? 8'h51 : 8'h71;
			7'd17: ch = plane ? 8'h57 : 8'h77;
			7'd18: ch = plane ? 8'h45 : 8'h65;
			7'd19: ch = plane ? 8'h52 : 8'h72;
			7'd20: ch = plane ? 8'h54 : 8'h74;
			7'd21: ch = plane ? 8'h59 : 8'h79;
			7'd22: ch = plane ? 8'h55 : 8'h75;
			7'd23: ch = plane ? 8'h49 : 8'h69;
			7'd24: ch = plane ? 8'h4F : 8'h6F;
			7'd25: ch = plane ? 8'h50 : 8'h70;
			7'd27: ch = plane ? 8'h7B : 8'h5B;
			7'd28: ch = 8'h0A;
			7'd30: ch = plane ? 8'h41 : 8'h61;
			7'd31: ch = plane ? 8'h53 : 8'h73;
			7'd32: ch = plane ? 8'h44 : 8'h64;
			7'd33: ch = plane ? 8'h46 : 8'h66;
			7'd34: ch = plane ? 8'h47 : 8'h67;
			7'd35: ch = plane ? 8'h48 : 8'h68;
			7'd36: ch = plane ? 8'h4A : 8'h6A;
			7'd37: ch = plane ? 8'h4B : 8'h6B;
			7'd38: ch = plane ? 8'h4C : 8'h6C;
			7'd40: ch = plane ? 8'h5E : 8'h7E;
			7'd41: ch = plane ? 8'h22 : 8'h27;
			7'd43: ch = plane ? 8'h7D : 8'h5D;
			7'd44: ch = plane ? 8'h5A : 8'h7A;
			7'd45: ch = plane ? 8'h58 : 8'h78;
			7'd46: ch = plane ? 8'h43 : 8'h63;
			7'd47: ch = plane ? 8'h56 : 8'h76;
			7'd48: ch = plane ? 8'h42 : 8'h62;
			7'd49: ch = plane ? 8'h4E : 8'h6E;
			7'd50: ch = plane ? 8'h4D : 8'h6D;
			7'd51: ch = plane ? 8'h3C : 8'h2C;
			7'd52: ch = plane ? 8'h3E : 8'h2E;
			7'd53: ch = plane ? 8'h3A : 8'h3B;
			7'd57: ch = 8'h20;
			7'd74: ch = 8'h2D;
			7'd78: ch = 8'h2B;
			7'd86: ch = plane ? 8'h7C : 8'h5C;
			default: ch = (idx == 7'd0 || idx > ROM_LAST) ? 8'h00 : NO_KEY;
		endcase
		return ch;
	endfunction

endpackage

// ===== rtl/core/scancode_to_ascii_key_fifo_top.sv =====
// Channel   Handshake             Payload
// request   start high, busy low  request.command, request.key_code
// result    done high one cycle   result.char_out, result.was_empty
//
// For a key event, ROM lookup and the character RAM write happen at acceptance.
// A read result comes from the registered read port of the character RAM.
// Busy is high in the cycle after a read is accepted, when done shows the result.
// Reset clears the pointers and the shift and caps flags; the RAM holds no reset value.
// The receiver cannot stall; each result is shown for exactly one cycle.
`include "assert_macros.svh"

module scancode_to_ascii_key_fifo_top #(
	parameter int BUFFER_DEPTH = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  scak_pkg::req_t      request,
	output logic                done,
	output scak_pkg::rsp_t      result
);

	localparam int PTR_W = $clog2(BUFFER_DEPTH);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(BUFFER_DEPTH - 1);

	logic [PTR_W-1:0] push_ptr_q;
	logic [PTR_W-1:0] pop_ptr_q;
	logic [PTR_W-1:0] push_next;
	logic [PTR_W-1:0] pop_next;
	logic             accept;
	logic             key_valid;
	logic             read_valid;
	logic             empty;
	logic             pend_s1;
	logic             empty_s1;
	logic [7:0]       rdata;
	scak_pkg::push_t  push;

	assign accept     = start && !busy;
	assign key_valid  = accept && (request.command == scak_pkg::CMD_KEY);
	assign read_valid = accept && (request.command == scak_pkg::CMD_READ);
	assign empty      = (push_ptr_q == pop_ptr_q);
	assign push_next  = (push_ptr_q == PTR_LAST) ? '0 : push_ptr_q + 1'b1;
	assign pop_next   = (pop_ptr_q == PTR_LAST) ? '0 : pop_ptr_q + 1'b1;

	scak_key_map u_key_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_valid (key_valid),
		.key_code  (request.key_code),
		.push      (push)
	);

	scak_char_ram #(
		.DEPTH (BUFFER_DEPTH)
	) u_char_ram (
		.clk   (clk),
		.we    (push.push),
		.waddr (push_ptr_q),
		.wdata (push.ch),
		.re    (read_valid && !empty),
		.raddr (pop_ptr_q),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			push_ptr_q <= '0;
			pop_ptr_q  <= '0;
			pend_s1    <= 1'b0;
		end else begin
			pend_s1 <= read_valid;
			if (push.push) begin
				push_ptr_q <= push_next;
				if (push_next == pop_ptr_q) begin
					pop_ptr_q <= pop_next;
				end
			end else if (read_valid && !empty) begin
				pop_ptr_q <= pop_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (read_valid) begin
			empty_s1 <= empty;
		end
	end

	assign busy             = pend_s1;
	assign done             = pend_s1;
	assign result.char_out  = empty_s1 ? 8'h00 : rdata;
	assign result.was_empty = empty_s1;

	`SCAK_ASSERT_NEXT(a_read_done, clk, arst_n, read_valid, done)
	`SCAK_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done)
	`SCAK_ASSERT_SAME(a_empty_zero, clk, arst_n, done && result.was_empty, result.char_out == 8'h00)
	`SCAK_ASSERT_NEXT(a_push_nonempty, clk, arst_n, push.push, push_ptr_q != pop_ptr_q)
	`SCAK_ASSERT_SAME(a_no_push_on_read, clk, arst_n, read_valid, !push.push)

endmodule

// ===== rtl/core/scak_key_map.sv =====
module scak_key_map (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                key_valid,
	input  logic [7:0]          key_code,
	output scak_pkg::push_t     push
);

	logic shift_armed_q;
	logic caps_lock_q;
	logic is_shift;
	logic is_caps;
	logic is_char;

	assign is_shift = (key_code == scak_pkg::SC_LSHIFT) || (key_code == scak_pkg::SC_RSHIFT);
	assign is_caps  = (key_code == scak_pkg::SC_CAPS);
	assign is_char  = key_valid && !key_code[7] && !is_shift && !is_caps;

	assign push.push = is_char;
	assign push.ch   = scak_pkg::rom_char(shift_armed_q ^ caps_lock_q, key_code[6:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_armed_q <= 1'b0;
			caps_lock_q   <= 1'b0;
		end else if (key_valid && !key_code[7]) begin
			if (is_shift) begin
				shift_armed_q <= 1'b1;
			end else if (is_caps) begin
				caps_lock_q <= ~caps_lock_q;
			end else begin
				shift_armed_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/scak_char_ram.sv =====
module scak_char_ram #(
	parameter  int DEPTH  = 256,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== tb/scancode_to_ascii_key_fifo_top_tb.sv =====
module scancode_to_ascii_key_fifo_top_tb;

	localparam int DEPTH = 256;
	localparam int LAST_CODE = 89;

	// Unshifted and shifted key planes, scancode 0 in the top byte.
	localparam logic [719:0] PLANE_LOWER = {
		8'h00, 8'hFF, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
		8'h30, 8'h2D, 8'h3D, 8'hFF, 8'hFF, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74,
		8'h79, 8'h75, 8'h69, 8'h6F, 8'h70, 8'hFF, 8'h5B, 8'h0A, 8'hFF, 8'h61,
		8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'hFF, 8'h7E,
		8'h27, 8'hFF, 8'h5D, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
		8'h2C, 8'h2E, 8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hFF, 8'hFF,
		{13{8'hFF}}, 8'h2D, {3{8'hFF}}, 8'h2B, {7{8'hFF}}, 8'h5C, {3{8'hFF}}
	};
	localparam logic [719:0] PLANE_UPPER = {
		8'h00, 8'hFF, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h3F, 8'h26, 8'h2A, 8'h28,
		8'h29, 8'h5F, 8'h2B, 8'hFF, 8'hFF, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54,
		8'h59, 8'h55, 8'h49, 8'h4F, 8'h50, 8'hFF, 8'h7B, 8'h0A, 8'hFF, 8'h41,
		8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'hFF, 8'h5E,
		8'h22, 8'hFF, 8'h7D, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
		8'h3C, 8'h3E, 8'h3A, 8'hFF, 8'hFF, 8'hFF, 8'h20, 8'hFF, 8'hFF, 8'hFF,
		{13{8'hFF}}, 8'h2D, {3{8'hFF}}, 8'h2B, {7{8'hFF}}, 8'h7C, {3{8'hFF}}
	};

	typedef struct {
		scak_pkg::req_t req;
		bit             hold;
	} keyboard_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	scak_pkg::req_t request = '0;
	logic busy;
	logic done;
	scak_pkg::rsp_t result;

	keyboard_item_t typed_items[$];
	scak_pkg::rsp_t awaited_reads[$];

	logic shift_armed_model;
	logic caps_model;
	logic [7:0] char_ring [DEPTH];
	int ring_wr;
	int ring_rd;

	int mismatches = 0;
	int chars_pushed = 0;
	int chars_dropped = 0;
	int reads_checked = 0;
	int empty_reads = 0;
	int ignored_keys = 0;
	int drain_waits = 0;
	int burst_left = 0;
	int gap_left = 0;
	int counted = 0;

	scancode_to_ascii_key_fifo_top #(
		.BUFFER_DEPTH(DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.request(request),
		.done(done),
		.result(result)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] glyph_for(logic plane, logic [7:0] code);
		if (code > LAST_CODE)
			return 8'h00;
		return plane ? PLANE_UPPER[(LAST_CODE - code) * 8 +: 8]
			: PLANE_LOWER[(LAST_CODE - code) * 8 +: 8];
	endfunction

	task automatic apply_keyboard_item(scak_pkg::req_t it);
		scak_pkg::rsp_t r;
		if (it.command == scak_pkg::CMD_READ) begin
			if (ring_rd == ring_wr) begin
				r.char_out = 8'h00;
				r.was_empty = 1'b1;
				empty_reads++;
			end else begin
				r.char_out = char_ring[ring_rd];
				r.was_empty = 1'b0;
				ring_rd = (ring_rd + 1) % DEPTH;
			end
			awaited_reads.push_back(r);
		end else if (it.key_code[7]) begin
			ignored_keys++;
		end else if (it.key_code == scak_pkg::SC_LSHIFT ||
			it.key_code == scak_pkg::SC_RSHIFT) begin
			shift_armed_model = 1'b1;
		end else if (it.key_code == scak_pkg::SC_CAPS) begin
			caps_model = ~caps_model;
		end else begin
			char_ring[ring_wr] = glyph_for(shift_armed_model ^ caps_model, it.key_code);
			ring_wr = (ring_wr + 1) % DEPTH;
			if (ring_wr == ring_rd) begin
				ring_rd = (ring_rd + 1) % DEPTH;
				chars_dropped++;
			end
			chars_pushed++;
			shift_armed_model = 1'b0;
		end
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	task automatic queue_item(logic cmd, logic [7:0] code, bit hold);
		keyboard_item_t k;
		k.req.command = cmd;
		k.req.key_code = code;
		k.hold = hold;
		typed_items.push_back(k);
		if (!(cmd == scak_pkg::CMD_KEY && code[7]))
			counted++;
	endtask

	function automatic logic [7:0] typing_code();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return scak_pkg::SC_LSHIFT;
		if (r < 10)
			return scak_pkg::SC_RSHIFT;
		if (r < 14)
			return scak_pkg::SC_CAPS;
		return 8'($urandom_range(0, 127));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		keyboard_item_t nxt;
		logic launch;
		if (!arst_n) begin
			start <= 1'b0;
			request <= '0;
		end else begin
			launch = start;
			if (start && !busy) begin
				apply_keyboard_item(request);
				launch = 1'b0;
			end
			if (!launch) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (typed_items.size() > 0) begin
					if (!typed_items[0].hold || awaited_reads.size() == 0) begin
						nxt = typed_items.pop_front();
						if (nxt.hold)
							drain_waits++;
						request <= nxt.req;
						launch = 1'b1;
						if (burst_left > 0) begin
							burst_left--;
						end else begin
							burst_left = $urandom_range(0, 24);
							gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
						end
					end
				end
			end
			start <= launch;
		end
	end

	always @(posedge clk) begin
		scak_pkg::rsp_t want;
		if (arst_n && done) begin
			if (awaited_reads.size() == 0) begin
				report_mismatch($sformatf("result with nothing awaited, char %h empty %b",
					result.char_out, result.was_empty));
			end else begin
				want = awaited_reads.pop_front();
				reads_checked++;
				if (result.char_out !== want.char_out)
					report_mismatch($sformatf("char_out %h, expected %h",
						result.char_out, want.char_out));
				if (result.was_empty !== want.was_empty)
					report_mismatch($sformatf("was_empty %b, expected %b",
						result.was_empty, want.was_empty));
			end
		end
	end

	initial begin
		int phase;
		int len;
		int r;
		shift_armed_model = 1'b0;
		caps_model = 1'b0;
		ring_wr = 0;
		ring_rd = 0;

		queue_item(scak_pkg::CMD_READ, 8'hFF, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd0, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd1, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd2, 1'b0);
		queue_item(scak_pkg::CMD_KEY, scak_pkg::SC_LSHIFT, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd16, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd16, 1'b0);
		queue_item(scak_pkg::CMD_KEY, scak_pkg::SC_CAPS, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd30, 1'b0);
		queue_item(scak_pkg::CMD_KEY, scak_pkg::SC_RSHIFT, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd30, 1'b0);
		queue_item(scak_pkg::CMD_KEY, scak_pkg::SC_CAPS, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd128, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd255, 1'b0);
		queue_item(scak_pkg::CMD_KEY, scak_pkg::SC_LSHIFT, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd200, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd127, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd90, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd89, 1'b0);
		queue_item(scak_pkg::CMD_KEY, 8'd86, 1'b0);
		for (int i = 0; i < 5; i++)
			queue_item(scak_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'b0);

		// Overrun the ring once for sure, then read it past empty.
		for (int i = 0; i < 290; i++)
			queue_item(scak_pkg::CMD_KEY, 8'($urandom_range(0, 40)), i == 0);
		for (int i = 0; i < 260; i++)
			queue_item(scak_pkg::CMD_READ, 8'($urandom_range(0, 255)), 1'b0);

		while (counted < 1330) begin
			phase = $urandom_range(0, 9);
			case (phase)
				0, 1, 2, 3, 4: begin
					len = $urandom_range(10, 60);
					for (int i = 0; i < len; i++) begin
						r = $urandom_range(0, 99);
						if (r < 60)
							queue_item(scak_pkg::CMD_KEY, typing_code(),
								i == 0 && phase == 0);
						else if (r < 90)
							queue_item(scak_pkg::CMD_READ, 8'($urandom),
								i == 0 && phase == 0);
						else
							queue_item(scak_pkg::CMD_KEY, 8'($urandom_range(128, 255)),
								1'b0);
					end
				end
				5, 6: begin
					len = $urandom_range(40, 300);
					for (int i = 0; i < len; i++) begin
						if ($urandom_range(0, 19) == 0)
							queue_item(scak_pkg::CMD_READ, 8'($urandom), 1'b0);
						else
							queue_item(scak_pkg::CMD_KEY, typing_code(), 1'b0);
					end
				end
				7, 8: begin
					len = $urandom_range(10, 80);
					for (int i = 0; i < len; i++)
						queue_item(scak_pkg::CMD_READ, 8'($urandom), i == 0);
				end
				default: begin
					len = $urandom_range(10, 30);
					for (int i = 0; i < len; i++)
						queue_item(1'($urandom), 8'($urandom), 1'b0);
				end
			endcase
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (typed_items.size() != 0 || start)
			@(posedge clk);
		while (awaited_reads.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);

		$display("Covered %0d pushed characters with %0d dropped on a full ring, %0d ignored codes.",
			chars_pushed, chars_dropped, ignored_keys);
		$display("Checked %0d reads, %0d of them on an empty ring; %0d drain pauses.",
			reads_checked, empty_reads, drain_waits);
		if (mismatches == 0) begin
			$display("PASS scancode_to_ascii_key_fifo_top");
		end else begin
			$display("FAIL scancode_to_ascii_key_fifo_top");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("FAIL scancode_to_ascii_key_fifo_top");
		$finish;
	end

endmodule
